/* rtl/core/sldf_pkg.sv */
// shared types and constants for the sync and length frame deframer
package sldf_pkg;

    localparam int POS_W      = 17;
    localparam int WORD_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int FIFO_DEPTH = 4;

    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'h23;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h64;
    localparam logic [BYTE_W-1:0] SYNC_THIRD  = 8'h01;

    localparam logic [POS_W-1:0] END_EXTRA = 17'd6;

    localparam logic [POS_W-1:0] OFF_HUNT       = 17'd0;
    localparam logic [POS_W-1:0] OFF_SYNC_2     = 17'd1;
    localparam logic [POS_W-1:0] OFF_SYNC_3     = 17'd2;
    localparam logic [POS_W-1:0] OFF_LEN_LO     = 17'd3;
    localparam logic [POS_W-1:0] OFF_LEN_HI     = 17'd4;
    localparam logic [POS_W-1:0] OFF_CMD_LO     = 17'd5;
    localparam logic [POS_W-1:0] OFF_CMD_HI     = 17'd6;
    localparam logic [POS_W-1:0] OFF_PLEN_LO    = 17'd7;
    localparam logic [POS_W-1:0] OFF_PLEN_HI    = 17'd8;
    localparam logic [POS_W-1:0] OFF_FIRST_DATA = 17'd9;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic [POS_W-1:0]  byte_offset;
        logic [WORD_W-1:0] command;
        logic [WORD_W-1:0] length_field;
        logic [WORD_W-1:0] payload_length;
        logic              last;
    } result_t;

endpackage

/* rtl/core/sldf_front.sv */
// front part: sync hunt, header capture and classification of each received item
module sldf_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [sldf_pkg::BYTE_W-1:0] rx_byte,
    output logic                        res_valid,
    output sldf_pkg::result_t           res
);

    logic [sldf_pkg::POS_W-1:0]  position_reg;
    logic [sldf_pkg::POS_W-1:0]  position_next;
    logic [sldf_pkg::POS_W-1:0]  frame_end_reg;
    logic [sldf_pkg::POS_W-1:0]  frame_end_next;
    logic [sldf_pkg::WORD_W-1:0] len_reg;
    logic [sldf_pkg::WORD_W-1:0] len_next;
    logic [sldf_pkg::WORD_W-1:0] cmd_reg;
    logic [sldf_pkg::WORD_W-1:0] cmd_next;
    logic [sldf_pkg::WORD_W-1:0] plen_reg;
    logic [sldf_pkg::WORD_W-1:0] plen_next;
    logic [sldf_pkg::POS_W:0]    pos_inc;
    logic                        is_data;
    logic                        is_last;

    assign pos_inc = {1'b0, position_reg} + {{sldf_pkg::POS_W{1'b0}}, 1'b1};
    assign is_data = (position_reg >= sldf_pkg::OFF_FIRST_DATA);
    assign is_last = pos_inc[sldf_pkg::POS_W]
                     || (pos_inc[sldf_pkg::POS_W-1:0] >= frame_end_reg);

    always_comb
    begin
        position_next  = position_reg;
        frame_end_next = frame_end_reg;
        len_next       = len_reg;
        cmd_next       = cmd_reg;
        plen_next      = plen_reg;
        if (in_valid)
        begin
            case (position_reg)
                sldf_pkg::OFF_HUNT:
                begin
                    if (rx_byte == sldf_pkg::SYNC_FIRST)
                    begin
                        position_next = sldf_pkg::OFF_SYNC_2;
                    end
                end
                sldf_pkg::OFF_SYNC_2:
                begin
                    position_next = (rx_byte == sldf_pkg::SYNC_SECOND)
                                    ? sldf_pkg::OFF_SYNC_3 : sldf_pkg::OFF_HUNT;
                end
                sldf_pkg::OFF_SYNC_3:
                begin
                    position_next = (rx_byte == sldf_pkg::SYNC_THIRD)
                                    ? sldf_pkg::OFF_LEN_LO : sldf_pkg::OFF_HUNT;
                end
                sldf_pkg::OFF_LEN_LO:
                begin
                    len_next[7:0] = rx_byte;
                    position_next = sldf_pkg::OFF_LEN_HI;
                end
                sldf_pkg::OFF_LEN_HI:
                begin
                    len_next[15:8] = rx_byte;
                    frame_end_next = {1'b0, rx_byte, len_reg[7:0]} + sldf_pkg::END_EXTRA;
                    position_next  = sldf_pkg::OFF_CMD_LO;
                end
                sldf_pkg::OFF_CMD_LO:
                begin
                    cmd_next[7:0] = rx_byte;
                    position_next = sldf_pkg::OFF_CMD_HI;
                end
                sldf_pkg::OFF_CMD_HI:
                begin
                    cmd_next[15:8] = rx_byte;
                    position_next  = sldf_pkg::OFF_PLEN_LO;
                end
                sldf_pkg::OFF_PLEN_LO:
                begin
                    plen_next[7:0] = rx_byte;
                    position_next  = sldf_pkg::OFF_PLEN_HI;
                end
                sldf_pkg::OFF_PLEN_HI:
                begin
                    plen_next[15:8] = rx_byte;
                    position_next   = sldf_pkg::OFF_FIRST_DATA;
                end
                default:
                begin
                    position_next = is_last ? sldf_pkg::OFF_HUNT
                                            : pos_inc[sldf_pkg::POS_W-1:0];
                end
            endcase
        end
    end

    always_comb
    begin
        res_valid          = in_valid && is_data;
        res.payload_byte   = rx_byte;
        res.byte_offset    = position_reg;
        res.command        = cmd_reg;
        res.length_field   = len_reg;
        res.payload_length = plen_reg;
        res.last           = is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= sldf_pkg::OFF_HUNT;
        end
        else
        begin
            position_reg <= position_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_end_reg <= '0;
            len_reg       <= '0;
            cmd_reg       <= '0;
            plen_reg      <= '0;
        end
        else
        begin
            frame_end_reg <= frame_end_next;
            len_reg       <= len_next;
            cmd_reg       <= cmd_next;
            plen_reg      <= plen_next;
        end
    end

endmodule

/* rtl/core/sldf_queue.sv */
// back part: result queue that holds items until they are popped
module sldf_queue #(
    parameter int DEPTH = sldf_pkg::FIFO_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  sldf_pkg::result_t wr_data,
    input  logic              rd_en,
    output sldf_pkg::result_t rd_data,
    output logic              full,
    output logic              empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    sldf_pkg::result_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_ONE;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* rtl/core/sync_length_frame_deframer_unit.sv */
// top level of the sync and length frame deframer
// Takes one received byte per cycle whenever full is low. The front part hunts for the
// sync bytes 0x23 0x64 0x01, captures the frame length, command and payload length
// words, and turns every frame byte from offset 9 to the frame end (length plus 6,
// ten bytes at least) into one result item; sync and header bytes give none. Each result
// item is written into a result queue of FIFO_DEPTH entries and is shown on the output
// ports once the items before it are popped; full rises only when that queue is full, so
// with pop held high full stays low and the block takes one byte per cycle.
module sync_length_frame_deframer_unit #(
    parameter int FIFO_DEPTH = sldf_pkg::FIFO_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [sldf_pkg::BYTE_W-1:0] rx_byte,
    output logic                        empty,
    input  logic                        pop,
    output logic [sldf_pkg::BYTE_W-1:0] payload_byte,
    output logic [sldf_pkg::POS_W-1:0]  byte_offset,
    output logic [sldf_pkg::WORD_W-1:0] command,
    output logic [sldf_pkg::WORD_W-1:0] length_field,
    output logic [sldf_pkg::WORD_W-1:0] payload_length,
    output logic                        last
);

    logic              in_accept;
    logic              res_valid;
    sldf_pkg::result_t res;
    sldf_pkg::result_t head;

    assign in_accept = push && !full;

    sldf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_accept),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    sldf_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res),
        .rd_en   (pop),
        .rd_data (head),
        .full    (full),
        .empty   (empty)
    );

    assign payload_byte   = head.payload_byte;
    assign byte_offset    = head.byte_offset;
    assign command        = head.command;
    assign length_field   = head.length_field;
    assign payload_length = head.payload_length;
    assign last           = head.last;

    a_not_full_and_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(full && empty))
        else $error("queue reports full and empty together");

    a_offset_min: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (byte_offset >= sldf_pkg::OFF_FIRST_DATA))
        else $error("result item with a header offset");

    a_offset_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((byte_offset == sldf_pkg::OFF_FIRST_DATA)
                    || ({1'b0, length_field} + sldf_pkg::END_EXTRA > byte_offset)))
        else $error("result item beyond the frame end");

    a_pop_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !(push && !full)) |=> !full)
        else $error("queue still full after a pop without a push");

endmodule

/* tb/sync_length_frame_deframer_unit_test.sv */
// self-checking testbench for the sync and length frame deframer
module sync_length_frame_deframer_unit_test;

    localparam int IDLE_PCT     = 12;
    localparam int RANDOM_ITEMS = 1290;
    localparam int HOLD_CYCLES  = 300;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        push = 1'b0;
    logic [sldf_pkg::BYTE_W-1:0] rx_byte = '0;
    logic                        pop = 1'b0;
    logic                        full;
    logic                        empty;
    logic [sldf_pkg::BYTE_W-1:0] payload_byte;
    logic [sldf_pkg::POS_W-1:0]  byte_offset;
    logic [sldf_pkg::WORD_W-1:0] command;
    logic [sldf_pkg::WORD_W-1:0] length_field;
    logic [sldf_pkg::WORD_W-1:0] payload_length;
    logic                        last;

    // predictor state
    logic [sldf_pkg::POS_W-1:0]  frame_pos;
    logic [sldf_pkg::POS_W-1:0]  frame_end;
    logic [sldf_pkg::WORD_W-1:0] cmd_word;
    logic [sldf_pkg::WORD_W-1:0] plen_word;

    sldf_pkg::result_t pending_payload[$];

    bit idle_on = 1'b1;
    int hold_req = 0;
    int bytes_sent = 0;
    int payload_checked = 0;
    int frames_closed = 0;
    int mismatches = 0;

    sync_length_frame_deframer_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .rx_byte        (rx_byte),
        .empty          (empty),
        .pop            (pop),
        .payload_byte   (payload_byte),
        .byte_offset    (byte_offset),
        .command        (command),
        .length_field   (length_field),
        .payload_length (payload_length),
        .last           (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void deframe_byte(input logic [sldf_pkg::BYTE_W-1:0] b);
        logic [sldf_pkg::POS_W-1:0] next_pos;
        logic                       closes;
        sldf_pkg::result_t          r;
        case (frame_pos)
            sldf_pkg::OFF_HUNT:
                if (b == sldf_pkg::SYNC_FIRST)
                    frame_pos = sldf_pkg::OFF_SYNC_2;
            sldf_pkg::OFF_SYNC_2:
                frame_pos = (b == sldf_pkg::SYNC_SECOND) ? sldf_pkg::OFF_SYNC_3
                                                         : sldf_pkg::OFF_HUNT;
            sldf_pkg::OFF_SYNC_3:
                frame_pos = (b == sldf_pkg::SYNC_THIRD) ? sldf_pkg::OFF_LEN_LO
                                                        : sldf_pkg::OFF_HUNT;
            sldf_pkg::OFF_LEN_LO:
            begin
                frame_end = {9'd0, b};
                frame_pos = sldf_pkg::OFF_LEN_HI;
            end
            sldf_pkg::OFF_LEN_HI:
            begin
                frame_end = frame_end + {1'b0, b, 8'd0} + sldf_pkg::END_EXTRA;
                frame_pos = sldf_pkg::OFF_CMD_LO;
            end
            sldf_pkg::OFF_CMD_LO:
            begin
                cmd_word = {8'd0, b};
                frame_pos = sldf_pkg::OFF_CMD_HI;
            end
            sldf_pkg::OFF_CMD_HI:
            begin
                cmd_word[15:8] = b;
                frame_pos = sldf_pkg::OFF_PLEN_LO;
            end
            sldf_pkg::OFF_PLEN_LO:
            begin
                plen_word = {8'd0, b};
                frame_pos = sldf_pkg::OFF_PLEN_HI;
            end
            sldf_pkg::OFF_PLEN_HI:
            begin
                plen_word[15:8] = b;
                frame_pos = sldf_pkg::OFF_FIRST_DATA;
            end
            default:
            begin
                next_pos = frame_pos + sldf_pkg::POS_W'(1);
                closes = (next_pos >= frame_end) || (next_pos < frame_pos);
                r.payload_byte   = b;
                r.byte_offset    = frame_pos;
                r.command        = cmd_word;
                r.length_field   = (frame_end >= sldf_pkg::END_EXTRA) ?
                                   sldf_pkg::WORD_W'(frame_end - sldf_pkg::END_EXTRA) : '0;
                r.payload_length = plen_word;
                r.last           = closes;
                pending_payload.push_back(r);
                frame_pos = closes ? sldf_pkg::OFF_HUNT : next_pos;
            end
        endcase
    endfunction

    // accepted bytes feed the predictor
    always @(posedge clk)
    begin
        if (rst_n && push && !full)
            deframe_byte(rx_byte);
    end

    task automatic check_field(input string name, input logic [sldf_pkg::POS_W-1:0] exp_v,
                               input logic [sldf_pkg::POS_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            mismatches++;
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        end
    endtask

    always @(posedge clk)
    begin
        sldf_pkg::result_t e;
        if (rst_n && pop && !empty)
        begin
            if (pending_payload.size() == 0)
            begin
                mismatches++;
                $error("result item with nothing expected, offset %0d", byte_offset);
            end
            else
            begin
                e = pending_payload.pop_front();
                check_field("payload_byte", sldf_pkg::POS_W'(e.payload_byte),
                            sldf_pkg::POS_W'(payload_byte));
                check_field("byte_offset", e.byte_offset, byte_offset);
                check_field("command", sldf_pkg::POS_W'(e.command),
                            sldf_pkg::POS_W'(command));
                check_field("length_field", sldf_pkg::POS_W'(e.length_field),
                            sldf_pkg::POS_W'(length_field));
                check_field("payload_length", sldf_pkg::POS_W'(e.payload_length),
                            sldf_pkg::POS_W'(payload_length));
                check_field("last", sldf_pkg::POS_W'(e.last), sldf_pkg::POS_W'(last));
                payload_checked++;
                if (e.last)
                    frames_closed++;
            end
        end
    end

    // receiver side, with an optional long hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                pop <= 1'b0;
                for (int k = 1; k < hold_req; k++)
                    @(posedge clk);
                hold_req = 0;
            end
            else
                pop <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic send_byte(input logic [sldf_pkg::BYTE_W-1:0] b);
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_header(input logic [sldf_pkg::WORD_W-1:0] len,
                               input logic [sldf_pkg::WORD_W-1:0] cmd,
                               input logic [sldf_pkg::WORD_W-1:0] plen);
        send_byte(sldf_pkg::SYNC_FIRST);
        send_byte(sldf_pkg::SYNC_SECOND);
        send_byte(sldf_pkg::SYNC_THIRD);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        send_byte(cmd[7:0]);
        send_byte(cmd[15:8]);
        send_byte(plen[7:0]);
        send_byte(plen[15:8]);
    endtask

    task automatic send_frame(input logic [sldf_pkg::WORD_W-1:0] len);
        int data_bytes;
        data_bytes = (int'(len) + 6 < 10) ? 1 : int'(len) + 6 - 9;
        send_header(len, sldf_pkg::WORD_W'($urandom), sldf_pkg::WORD_W'($urandom));
        repeat (data_bytes)
            send_byte(sldf_pkg::BYTE_W'($urandom));
    endtask

    task automatic test_sync_errors;
        send_byte(sldf_pkg::SYNC_FIRST);
        send_byte(8'h00);
        send_byte(sldf_pkg::SYNC_FIRST);
        send_byte(sldf_pkg::SYNC_FIRST);
        send_byte(sldf_pkg::SYNC_SECOND);
        send_byte(sldf_pkg::SYNC_THIRD);
        send_byte(sldf_pkg::SYNC_FIRST);
        send_byte(sldf_pkg::SYNC_SECOND);
        send_byte(sldf_pkg::SYNC_FIRST);
        send_byte(sldf_pkg::SYNC_SECOND);
        send_byte(sldf_pkg::SYNC_THIRD);
        send_byte(sldf_pkg::SYNC_FIRST);
        send_byte(sldf_pkg::SYNC_SECOND);
        send_byte(8'hFF);
    endtask

    task automatic test_short_frame;
        send_header(16'h0000, 16'hFFFF, 16'h0000);
        send_byte(8'hFF);
    endtask

    task automatic test_back_pressure;
        hold_req = HOLD_CYCLES;
        send_frame(16'd60);
    endtask

    task automatic test_no_idle;
        idle_on = 1'b0;
        repeat (20)
            send_frame(sldf_pkg::WORD_W'($urandom_range(0, 40)));
        idle_on = 1'b1;
    endtask

    // opening bytes of a maximum-length frame
    task automatic test_max_frame;
        send_header(16'hFFFF, sldf_pkg::WORD_W'($urandom), sldf_pkg::WORD_W'($urandom));
        repeat (40)
            send_byte(sldf_pkg::BYTE_W'($urandom));
    endtask

    task automatic test_random_traffic;
        int start_count;
        int pick;
        start_count = bytes_sent;
        while (bytes_sent - start_count < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                send_frame(sldf_pkg::WORD_W'($urandom_range(0, 3)));
            else if (pick < 12)
                send_frame(sldf_pkg::WORD_W'($urandom_range(16'h0100, 16'h0130)));
            else if (pick < 75)
                send_frame(sldf_pkg::WORD_W'($urandom_range(4, 40)));
            else if (pick < 88)
            begin
                repeat ($urandom_range(1, 6))
                    send_byte(($urandom_range(0, 3) == 0) ? sldf_pkg::SYNC_FIRST :
                              sldf_pkg::BYTE_W'($urandom));
            end
            else
            begin
                send_byte(sldf_pkg::SYNC_FIRST);
                if ($urandom_range(0, 1) == 0)
                    send_byte(sldf_pkg::BYTE_W'($urandom_range(0, 1) ?
                                                sldf_pkg::SYNC_FIRST : 8'h65));
                else
                begin
                    send_byte(sldf_pkg::SYNC_SECOND);
                    send_byte(sldf_pkg::BYTE_W'($urandom_range(0, 1) ?
                                                sldf_pkg::SYNC_FIRST : 8'h00));
                end
            end
        end
    endtask

    initial
    begin
        frame_pos = sldf_pkg::OFF_HUNT;
        frame_end = '0;
        cmd_word  = '0;
        plen_word = '0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_sync_errors();
        test_short_frame();
        test_back_pressure();
        test_no_idle();
        test_random_traffic();
        test_max_frame();

        push <= 1'b0;
        for (int guard = 0; guard < 5000 && pending_payload.size() > 0; guard++)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
        if (pending_payload.size() > 0)
        begin
            mismatches++;
            $error("%0d expected result items never arrived", pending_payload.size());
        end

        $display("sent %0d bytes incl. sync faults, short, long and maximum-length frames",
                 bytes_sent);
        $display("checked %0d payload items across %0d completed frames",
                 payload_checked, frames_closed);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
